// ----- rtl/core/arbp_pkg.sv -----
`timescale 1ns / 1ps

package arbp_pkg;

  // Default pool geometry
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int RING_DEPTH_DEF = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [4:0] TRAILS_RESET = 5'd16;
  localparam logic [6:0] LIMIT_RESET  = 7'd64;

  // Allocation floors and unit direction
  localparam logic [31:0] MIN_LIFETIME = 32'd655;
  localparam logic [15:0] MIN_WIDTH    = 16'd26;
  localparam logic [14:0] UNIT_DIR     = 15'd16384;

  // Point word layout: {pos_y, pos_x, dir_y, dir_x, thickness, color, remaining life}
  localparam int LIFE_W  = 32;
  localparam int POINT_W = 64 + 32 + 16 + 32 + LIFE_W;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic alloc;
    logic free_slot;
    logic clear_all;
    logic norm_start;
    logic append;
    logic tick_init;
    logic next_slot;
    logic pt_init;
    logic pt_read;
    logic pt_write;
    logic slot_done;
    logic respond;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] req;
    logic       app_ok;
    logic       dt_nz;
    logic       norm_done;
    logic       has_points;
    logic       last_slot;
    logic       last_point;
  } sts_t;

endpackage

// ----- rtl/core/arbp_ram.sv -----
`timescale 1ns / 1ps

module arbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/arbp_norm.sv -----
`timescale 1ns / 1ps

module arbp_norm import arbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  output logic               done_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o
);

  typedef enum logic [8:0] {
    N_IDLE = 9'b000000001,
    N_SQX  = 9'b000000010,
    N_SQY  = 9'b000000100,
    N_SUM  = 9'b000001000,
    N_D2   = 9'b000010000,
    N_PLO  = 9'b000100000,
    N_PHI  = 9'b001000000,
    N_CMP  = 9'b010000000,
    N_DONE = 9'b100000000
  } norm_state_e;

  norm_state_e state_q, state_d;
  logic        comp_q;
  logic [16:0] mx_q, my_q;
  logic        negx_q, negy_q;
  logic [30:0] sqx_q, sqy_q;
  logic [31:0] s_q;
  logic [14:0] n_q, bit_q, t_q;
  logic [29:0] d2_q;
  logic [45:0] plo_q, phi_q;
  logic [15:0] nx_q, ny_q;

  logic [16:0] mx_in, my_in;
  logic [15:0] t_sum, d_val;
  logic        t_fits;
  logic [31:0] sum_sq;
  logic [60:0] rhs;
  logic [61:0] prod;
  logic        le;
  logic [14:0] n_upd;
  logic        neg_sel;
  logic [15:0] res;
  logic        advance, finish;

  // Magnitudes of the inputs
  assign mx_in = dir_x_i[15] ? (17'd0 - {1'b1, dir_x_i}) : {1'b0, dir_x_i};
  assign my_in = dir_y_i[15] ? (17'd0 - {1'b1, dir_y_i}) : {1'b0, dir_y_i};

  // Trial bit and its odd test value 2t-1
  assign t_sum  = {1'b0, n_q} + {1'b0, bit_q};
  assign t_fits = t_sum <= {1'b0, UNIT_DIR};
  assign d_val  = {t_sum[14:0], 1'b0} - 16'd1;

  // Compare (2t-1)^2 * s against c^2 * 2^30
  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rhs    = {(comp_q ? sqy_q : sqx_q), 30'd0};
  assign prod   = {phi_q, 16'd0} + {16'd0, plo_q};
  assign le     = prod <= {1'b0, rhs};
  assign n_upd  = (state_q == N_CMP && le) ? t_q : n_q;

  assign neg_sel = comp_q ? negy_q : negx_q;
  assign res     = neg_sel ? (16'd0 - {1'b0, n_upd}) : {1'b0, n_upd};

  assign advance = (state_q == N_CMP) || (state_q == N_D2 && !t_fits);
  assign finish  = advance && bit_q[0] && comp_q;

  // Sequence the bit steps
  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE: if (start_i) state_d = N_SQX;
      N_SQX:  state_d = N_SQY;
      N_SQY:  state_d = N_SUM;
      N_SUM:  state_d = (sum_sq == 32'd0) ? N_DONE : N_D2;
      N_D2: begin
        if (t_fits) state_d = N_PLO;
        else if (finish) state_d = N_DONE;
      end
      N_PLO:  state_d = N_PHI;
      N_PHI:  state_d = N_CMP;
      N_CMP:  state_d = finish ? N_DONE : N_D2;
      N_DONE: state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      comp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == N_SUM) comp_q <= 1'b0;
      else if (advance && bit_q[0]) comp_q <= 1'b1;
    end
  end

  // Datapath of the normalizer
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        mx_q   <= mx_in;
        my_q   <= my_in;
        negx_q <= dir_x_i[15];
        negy_q <= dir_y_i[15];
      end
      N_SQX: sqx_q <= 31'(mx_q * mx_q);
      N_SQY: sqy_q <= 31'(my_q * my_q);
      N_SUM: begin
        s_q   <= sum_sq;
        n_q   <= '0;
        bit_q <= UNIT_DIR;
        nx_q  <= {1'b0, UNIT_DIR};
        ny_q  <= '0;
      end
      N_D2: begin
        t_q  <= t_sum[14:0];
        d2_q <= 30'(d_val * d_val);
      end
      N_PLO: plo_q <= 46'(d2_q * s_q[15:0]);
      N_PHI: phi_q <= 46'(d2_q * s_q[31:16]);
      default: ;
    endcase
    if (advance) begin
      if (bit_q[0]) begin
        if (comp_q) ny_q <= res;
        else nx_q <= res;
        n_q   <= '0;
        bit_q <= UNIT_DIR;
      end else begin
        n_q   <= n_upd;
        bit_q <= bit_q >> 1;
      end
    end
  end

  assign done_o   = (state_q == N_DONE);
  assign norm_x_o = nx_q;
  assign norm_y_o = ny_q;

endmodule

// ----- rtl/core/arbp_dpath.sv -----
`timescale 1ns / 1ps

module arbp_dpath import arbp_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [2:0]            req_type_i,
  input  logic [3:0]            slot_number_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [15:0]    dir_x_i,
  input  logic signed [15:0]    dir_y_i,
  input  logic signed [15:0]    point_width_i,
  input  logic [31:0]           point_color_i,
  input  logic [31:0]           elapsed_time_i,
  input  logic [6:0]            alloc_length_i,
  input  logic [31:0]           alloc_lifetime_i,
  input  logic [15:0]           alloc_width_start_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  ok_o,
  output logic [3:0]            granted_slot_o,
  output logic [6:0]            live_points_o,
  output logic [5:0]            head_position_o,
  output logic [5:0]            written_index_o,
  output logic signed [15:0]    stored_dir_x_o,
  output logic signed [15:0]    stored_dir_y_o,
  output logic [15:0]           stored_width_o,
  output logic [31:0]           stored_lifetime_o,
  output logic [4:0]            active_slots_o
);

  localparam int SLW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TRW   = ($clog2(NUM_SLOTS + 1) > 5) ? $clog2(NUM_SLOTS + 1) : 5;
  localparam int ACW   = $clog2(NUM_SLOTS + 1);
  localparam int HW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int LMW   = (CW > 7) ? CW : 7;
  localparam int DEPTH = NUM_SLOTS * RING_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [4:0] trails_q;
  logic [6:0] limit_q;

  // Latched request
  logic [2:0]         req_q;
  logic [3:0]         sn_q;
  logic [31:0]        posx_q, posy_q, color_q, dt_q, alife_q;
  logic signed [15:0] dirx_q, diry_q, pw_q;
  logic [6:0]         alen_q;
  logic [15:0]        awid_q;

  // Slot table
  logic          active_q  [NUM_SLOTS];
  logic [CW-1:0] len_q     [NUM_SLOTS];
  logic [31:0]   lifelim_q [NUM_SLOTS];
  logic [15:0]   wdef_q    [NUM_SLOTS];
  logic [HW-1:0] head_q    [NUM_SLOTS];
  logic [CW-1:0] cnt_q     [NUM_SLOTS];

  // Working registers
  logic [SLW-1:0] sel_q;
  logic           av_q;
  logic [ACW-1:0] act_q;
  logic [CW-1:0]  i_q, ncnt_q;
  logic           trim_q;

  // Result registers
  logic          ok_q;
  logic [3:0]    gr_q;
  logic [HW-1:0] widx_q;
  logic [15:0]   sdx_q, sdy_q, sw_q;
  logic [31:0]   sl_q;

  // Output registers
  logic        done_q, out_ok_q;
  logic [3:0]  out_gr_q;
  logic [6:0]  out_live_q;
  logic [5:0]  out_head_q, out_widx_q;
  logic [15:0] out_dx_q, out_dy_q, out_sw_q;
  logic [31:0] out_sl_q;
  logic [4:0]  out_act_q;

  logic [TRW-1:0] trails_ext, ntr;
  logic [LMW-1:0] limit_ext, lim, alen_ext, alen_lo, alen_c;
  logic           found;
  logic [SLW-1:0] fidx;
  logic           a_act;
  logic [CW-1:0]  a_len, a_cnt, hp1, h_ext, tidx, app_c;
  logic [31:0]    a_life;
  logic [15:0]    a_wdef, app_sw;
  logic [HW-1:0]  a_head, app_w;
  logic [AW-1:0]  base, app_addr, t_addr;
  logic           norm_done;
  logic [15:0]    ndx, ndy;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [POINT_W-1:0] ram_wdata, ram_rdata;
  logic [LIFE_W-1:0]  life_rd, life_nv;

  assign cfg_ready_o = 1'b1;

  // Clamp the registers to their usable ranges
  assign trails_ext = TRW'(trails_q);
  assign ntr = (trails_ext == '0) ? TRW'(1) :
               ((trails_ext > TRW'(NUM_SLOTS)) ? TRW'(NUM_SLOTS) : trails_ext);
  assign limit_ext = LMW'(limit_q);
  assign lim = (limit_ext < LMW'(2)) ? LMW'(2) :
               ((limit_ext > LMW'(RING_DEPTH)) ? LMW'(RING_DEPTH) : limit_ext);

  // Find the lowest free usable slot
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!found && !active_q[s] && (TRW'(s) < ntr)) begin
        found = 1'b1;
        fidx  = SLW'(s);
      end
    end
  end

  assign alen_ext = LMW'(alen_q);
  assign alen_lo  = (alen_ext < LMW'(2)) ? LMW'(2) : alen_ext;
  assign alen_c   = (alen_lo > lim) ? lim : alen_lo;

  // Selected slot
  assign a_act  = active_q[sel_q];
  assign a_len  = len_q[sel_q];
  assign a_cnt  = cnt_q[sel_q];
  assign a_head = head_q[sel_q];
  assign a_life = lifelim_q[sel_q];
  assign a_wdef = wdef_q[sel_q];

  // Next ring index for append
  assign hp1    = CW'(a_head) + CW'(1);
  assign app_w  = (a_cnt == '0) ? '0 : ((hp1 == a_len) ? '0 : HW'(hp1));
  assign app_c  = (a_cnt == '0) ? CW'(1) : ((a_cnt < a_len) ? a_cnt + CW'(1) : a_cnt);
  assign app_sw = (pw_q > 16'sd0) ? pw_q : a_wdef;

  // Ring index of the point i steps behind the head
  assign h_ext = CW'(a_head);
  assign tidx  = (h_ext >= i_q) ? (h_ext - i_q) : ((a_len - i_q) + h_ext);

  assign base     = AW'(sel_q) * AW'(RING_DEPTH);
  assign app_addr = base + AW'(app_w);
  assign t_addr   = base + AW'(tidx);

  // Age one point
  assign life_rd = ram_rdata[LIFE_W-1:0];
  assign life_nv = (life_rd > dt_q) ? (life_rd - dt_q) : '0;

  assign ram_we    = cmd_i.append || cmd_i.pt_write;
  assign ram_waddr = cmd_i.append ? app_addr : t_addr;
  assign ram_wdata = cmd_i.append ?
                     {posy_q, posx_q, ndy, ndx, app_sw, color_q, a_life} :
                     {ram_rdata[POINT_W-1:LIFE_W], life_nv};

  arbp_ram #(
    .WIDTH (POINT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pt_read),
    .raddr_i (t_addr),
    .rdata_o (ram_rdata)
  );

  arbp_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.norm_start),
    .dir_x_i  (dirx_q),
    .dir_y_i  (diry_q),
    .done_o   (norm_done),
    .norm_x_o (ndx),
    .norm_y_o (ndy)
  );

  // Status to the controller
  assign sts_o.req        = req_q;
  assign sts_o.app_ok     = av_q && a_act;
  assign sts_o.dt_nz      = (dt_q != '0);
  assign sts_o.norm_done  = norm_done;
  assign sts_o.has_points = a_act && (a_cnt != '0);
  assign sts_o.last_slot  = (sel_q == SLW'(NUM_SLOTS - 1));
  assign sts_o.last_point = (i_q == '0);

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_type_i;
      sn_q    <= slot_number_i;
      posx_q  <= pos_x_i;
      posy_q  <= pos_y_i;
      dirx_q  <= dir_x_i;
      diry_q  <= dir_y_i;
      pw_q    <= point_width_i;
      color_q <= point_color_i;
      dt_q    <= elapsed_time_i;
      alen_q  <= alloc_length_i;
      alife_q <= alloc_lifetime_i;
      awid_q  <= alloc_width_start_i;
    end
  end

  // Slot table, working state and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trails_q   <= TRAILS_RESET;
      limit_q    <= LIMIT_RESET;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        active_q[s]  <= 1'b0;
        len_q[s]     <= CW'(RING_DEPTH);
        lifelim_q[s] <= '0;
        wdef_q[s]    <= '0;
        head_q[s]    <= '0;
        cnt_q[s]     <= '0;
      end
      sel_q      <= '0;
      av_q       <= 1'b0;
      act_q      <= '0;
      i_q        <= '0;
      ncnt_q     <= '0;
      trim_q     <= 1'b0;
      ok_q       <= 1'b0;
      gr_q       <= '0;
      widx_q     <= '0;
      sdx_q      <= '0;
      sdy_q      <= '0;
      sw_q       <= '0;
      sl_q       <= '0;
      done_q     <= 1'b0;
      out_ok_q   <= 1'b0;
      out_gr_q   <= '0;
      out_live_q <= '0;
      out_head_q <= '0;
      out_widx_q <= '0;
      out_dx_q   <= '0;
      out_dy_q   <= '0;
      out_sw_q   <= '0;
      out_sl_q   <= '0;
      out_act_q  <= '0;
    end else begin
      // Configuration beat
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TRAILS: trails_q <= cfg_data_i[4:0];
          CFG_LIMIT:  limit_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (cmd_i.latch) begin
        sel_q  <= SLW'(TRW'(slot_number_i));
        av_q   <= TRW'(slot_number_i) < ntr;
        gr_q   <= slot_number_i;
        ok_q   <= 1'b0;
        widx_q <= '0;
        sdx_q  <= '0;
        sdy_q  <= '0;
        sw_q   <= '0;
        sl_q   <= '0;
      end

      // Take the first free slot
      if (cmd_i.alloc) begin
        if (found) begin
          active_q[fidx]  <= 1'b1;
          len_q[fidx]     <= CW'(alen_c);
          lifelim_q[fidx] <= (alife_q < MIN_LIFETIME) ? MIN_LIFETIME : alife_q;
          wdef_q[fidx]    <= (awid_q < MIN_WIDTH) ? MIN_WIDTH : awid_q;
          head_q[fidx]    <= '0;
          cnt_q[fidx]     <= '0;
          act_q           <= act_q + ACW'(1);
          ok_q            <= 1'b1;
          sel_q           <= fidx;
          gr_q            <= 4'(fidx);
          av_q            <= 1'b1;
        end else begin
          gr_q <= '0;
          av_q <= 1'b0;
        end
      end

      // Release the addressed slot
      if (cmd_i.free_slot && av_q && a_act) begin
        active_q[sel_q] <= 1'b0;
        head_q[sel_q]   <= '0;
        cnt_q[sel_q]    <= '0;
        act_q           <= act_q - ACW'(1);
        ok_q            <= 1'b1;
      end

      // Release every slot
      if (cmd_i.clear_all) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          active_q[s] <= 1'b0;
          head_q[s]   <= '0;
          cnt_q[s]    <= '0;
        end
        act_q <= '0;
        ok_q  <= 1'b1;
      end

      // Advance the ring and report the stored point
      if (cmd_i.append) begin
        head_q[sel_q] <= app_w;
        cnt_q[sel_q]  <= app_c;
        widx_q        <= app_w;
        sdx_q         <= ndx;
        sdy_q         <= ndy;
        sw_q          <= app_sw;
        sl_q          <= a_life;
        ok_q          <= 1'b1;
      end

      // Walk the slots for a tick
      if (cmd_i.tick_init) begin
        sel_q <= '0;
        ok_q  <= 1'b1;
      end
      if (cmd_i.pt_init) begin
        i_q    <= a_cnt - CW'(1);
        ncnt_q <= a_cnt;
        trim_q <= 1'b1;
      end
      if (cmd_i.pt_write) begin
        i_q <= i_q - CW'(1);
        if (trim_q && life_nv == '0) ncnt_q <= ncnt_q - CW'(1);
        else trim_q <= 1'b0;
      end
      if (cmd_i.slot_done) begin
        cnt_q[sel_q] <= ncnt_q;
        if (ncnt_q == '0) head_q[sel_q] <= '0;
      end
      if (cmd_i.next_slot) begin
        if (sel_q == SLW'(NUM_SLOTS - 1)) sel_q <= SLW'(TRW'(sn_q));
        else sel_q <= sel_q + SLW'(1);
      end

      // Drive the result beat for one cycle
      done_q <= cmd_i.respond;
      if (cmd_i.respond) begin
        out_ok_q   <= ok_q;
        out_gr_q   <= gr_q;
        out_live_q <= av_q ? 7'(a_cnt) : '0;
        out_head_q <= av_q ? 6'(a_head) : '0;
        out_widx_q <= 6'(widx_q);
        out_dx_q   <= sdx_q;
        out_dy_q   <= sdy_q;
        out_sw_q   <= sw_q;
        out_sl_q   <= sl_q;
        out_act_q  <= 5'(act_q);
      end
    end
  end

  assign done_o            = done_q;
  assign ok_o              = out_ok_q;
  assign granted_slot_o    = out_gr_q;
  assign live_points_o     = out_live_q;
  assign head_position_o   = out_head_q;
  assign written_index_o   = out_widx_q;
  assign stored_dir_x_o    = out_dx_q;
  assign stored_dir_y_o    = out_dy_q;
  assign stored_width_o    = out_sw_q;
  assign stored_lifetime_o = out_sl_q;
  assign active_slots_o    = out_act_q;

endmodule

// ----- rtl/core/arbp_ctrl.sv -----
`timescale 1ns / 1ps

module arbp_ctrl import arbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DECODE = 8'b00000010,
    S_NORM   = 8'b00000100,
    S_TSLOT  = 8'b00001000,
    S_TRD    = 8'b00010000,
    S_TWR    = 8'b00100000,
    S_TEND   = 8'b01000000,
    S_RESP   = 8'b10000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Issue commands per state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        case (sts_i.req)
          REQ_ALLOC:  cmd_o.alloc = 1'b1;
          REQ_FREE:   cmd_o.free_slot = 1'b1;
          REQ_CLEAR:  cmd_o.clear_all = 1'b1;
          REQ_APPEND: begin
            if (sts_i.app_ok) begin
              cmd_o.norm_start = 1'b1;
              state_d          = S_NORM;
            end
          end
          REQ_TICK: begin
            if (sts_i.dt_nz) begin
              cmd_o.tick_init = 1'b1;
              state_d         = S_TSLOT;
            end
          end
          default: ;
        endcase
      end
      S_NORM: begin
        if (sts_i.norm_done) begin
          cmd_o.append = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_TSLOT: begin
        if (sts_i.has_points) begin
          cmd_o.pt_init = 1'b1;
          state_d       = S_TRD;
        end else begin
          cmd_o.next_slot = 1'b1;
          if (sts_i.last_slot) state_d = S_RESP;
        end
      end
      S_TRD: begin
        cmd_o.pt_read = 1'b1;
        state_d       = S_TWR;
      end
      S_TWR: begin
        cmd_o.pt_write = 1'b1;
        state_d        = sts_i.last_point ? S_TEND : S_TRD;
      end
      S_TEND: begin
        cmd_o.slot_done = 1'b1;
        cmd_o.next_slot = 1'b1;
        state_d         = sts_i.last_slot ? S_RESP : S_TSLOT;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/aging_ring_buffer_pool.sv -----
`timescale 1ns / 1ps

// Pool of trail slots, each a ring of aging points. One request at a time: a request is
// taken when start_i is high and busy_o low, and its single result appears on the result
// ports for exactly one cycle with done_o high; the receiver cannot stall, so capture it
// then. Allocate, free, clear-all, rejected and unknown requests go from the decode state
// straight to the response state, which registers the result beat. Append waits on the
// bit-serial direction normalizer, which handles both components in turn: it squares
// each component and sums the squares, then tries fifteen trial bits per component
// (square of the odd test value, two partial products, compare), skipping the products
// when the trial value is out of range; a zero vector skips the trials. Tick visits every
// slot in turn and, in each slot that holds points, reads each live point from the point
// memory and writes it back aged.
// Configuration writes are always ready and must only be issued while busy_o is low.
module aging_ring_buffer_pool import arbp_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            req_type_i,
  input  logic [3:0]            slot_number_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [15:0]    dir_x_i,
  input  logic signed [15:0]    dir_y_i,
  input  logic signed [15:0]    point_width_i,
  input  logic [31:0]           point_color_i,
  input  logic [31:0]           elapsed_time_i,
  input  logic [6:0]            alloc_length_i,
  input  logic [31:0]           alloc_lifetime_i,
  input  logic [15:0]           alloc_width_start_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  ok_o,
  output logic [3:0]            granted_slot_o,
  output logic [6:0]            live_points_o,
  output logic [5:0]            head_position_o,
  output logic [5:0]            written_index_o,
  output logic signed [15:0]    stored_dir_x_o,
  output logic signed [15:0]    stored_dir_y_o,
  output logic [15:0]           stored_width_o,
  output logic [31:0]           stored_lifetime_o,
  output logic [4:0]            active_slots_o
);

  cmd_t cmd;
  sts_t sts;

  arbp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  arbp_dpath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_type_i          (req_type_i),
    .slot_number_i       (slot_number_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .dir_x_i             (dir_x_i),
    .dir_y_i             (dir_y_i),
    .point_width_i       (point_width_i),
    .point_color_i       (point_color_i),
    .elapsed_time_i      (elapsed_time_i),
    .alloc_length_i      (alloc_length_i),
    .alloc_lifetime_i    (alloc_lifetime_i),
    .alloc_width_start_i (alloc_width_start_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .ok_o                (ok_o),
    .granted_slot_o      (granted_slot_o),
    .live_points_o       (live_points_o),
    .head_position_o     (head_position_o),
    .written_index_o     (written_index_o),
    .stored_dir_x_o      (stored_dir_x_o),
    .stored_dir_y_o      (stored_dir_y_o),
    .stored_width_o      (stored_width_o),
    .stored_lifetime_o   (stored_lifetime_o),
    .active_slots_o      (active_slots_o)
  );

`ifndef NO_ASSERTIONS
  // A result beat only leaves once the controller is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted request occupies the block and does not finish at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted request did not start");

  // Append fields stay clear on a rejected request
  a_reject_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (written_index_o == 6'd0 && stored_lifetime_o == 32'd0))
    else $error("append fields set on rejected request");
`endif

endmodule

// ----- tb/aging_ring_buffer_pool_tb.sv -----
`timescale 1ns / 1ps

module aging_ring_buffer_pool_tb import arbp_pkg::*;;

  localparam int          SLOTS       = 16;
  localparam int          DEPTH       = 64;
  localparam logic [2:0]  REQ_BAD     = 3'd5;
  localparam int          CYCLE_LIMIT = 10000000;
  localparam int          DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] wid;
    logic [31:0]        color;
    logic [31:0]        dt;
    logic [6:0]         len;
    logic [31:0]        life;
    logic [15:0]        wstart;
  } pool_req_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         slot;
    logic [6:0]         live;
    logic [5:0]         head;
    logic [5:0]         widx;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        wid;
    logic [31:0]        life;
    logic [4:0]         active;
  } pool_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] req_type_i = '0;
  logic [3:0] slot_number_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] point_width_i = '0;
  logic [31:0] point_color_i = '0;
  logic [31:0] elapsed_time_i = '0;
  logic [6:0] alloc_length_i = '0;
  logic [31:0] alloc_lifetime_i = '0;
  logic [15:0] alloc_width_start_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic done_o, ok_o;
  logic [3:0] granted_slot_o;
  logic [6:0] live_points_o;
  logic [5:0] head_position_o, written_index_o;
  logic signed [15:0] stored_dir_x_o, stored_dir_y_o;
  logic [15:0] stored_width_o;
  logic [31:0] stored_lifetime_o;
  logic [4:0] active_slots_o;

  aging_ring_buffer_pool uut (.*);

  // Pool shadow state
  logic        pool_active[SLOTS];
  logic [6:0]  pool_len[SLOTS];
  logic [31:0] pool_life_limit[SLOTS];
  logic [15:0] pool_width_def[SLOTS];
  logic [5:0]  pool_head[SLOTS];
  logic [6:0]  pool_count[SLOTS];
  logic [31:0] pt_life[SLOTS][DEPTH];
  logic [4:0]  cfg_trails;
  logic [6:0]  cfg_limit;

  pool_resp_t pending_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** aging_ring_buffer_pool: FAILED **");
      $finish;
    end
  end

  function automatic int usable_slots();
    if (cfg_trails < 1) return 1;
    if (cfg_trails > SLOTS) return SLOTS;
    return cfg_trails;
  endfunction

  function automatic int ring_limit();
    if (cfg_limit < 2) return 2;
    if (cfg_limit > DEPTH) return DEPTH;
    return cfg_limit;
  endfunction

  function automatic void wipe(int s);
    pool_active[s] = 1'b0;
    pool_len[s] = 7'(ring_limit());
    pool_life_limit[s] = '0;
    pool_width_def[s] = '0;
    pool_head[s] = '0;
    pool_count[s] = '0;
    for (int i = 0; i < DEPTH; i++) pt_life[s][i] = '0;
  endfunction

  // Largest n in 0..16384 with (2n-1)^2 * s <= c^2 * 2^30
  function automatic logic signed [15:0] unit_component(int c, longint unsigned s);
    longint unsigned m, rhs, d;
    int n, t;
    m = (c < 0) ? -c : c;
    rhs = (m * m) << 30;
    n = 0;
    for (int b = 16384; b != 0; b = b >> 1) begin
      t = n + b;
      if (t <= 16384) begin
        d = 2 * t - 1;
        if (d * d * s <= rhs) n = t;
      end
    end
    return (c < 0) ? 16'(-n) : 16'(n);
  endfunction

  // Apply one request to the shadow pool and return its result
  function automatic pool_resp_t apply_request(pool_req_t r);
    pool_resp_t o;
    int ntr, s, len, k, nact;
    bit addr_ok;
    int addr;
    longint unsigned sq;
    o = '{default: '0};
    ntr = usable_slots();
    addr = r.slot;
    addr_ok = r.slot < ntr;
    case (r.kind)
      REQ_ALLOC: begin
        addr_ok = 1'b0;
        addr = 0;
        for (s = 0; s < ntr; s++) begin
          if (!pool_active[s]) begin
            wipe(s);
            len = r.len;
            if (len < 2) len = 2;
            if (len > ring_limit()) len = ring_limit();
            pool_active[s] = 1'b1;
            pool_len[s] = 7'(len);
            pool_life_limit[s] = (r.life < MIN_LIFETIME) ? MIN_LIFETIME : r.life;
            pool_width_def[s] = (r.wstart < MIN_WIDTH) ? MIN_WIDTH : r.wstart;
            o.ok = 1'b1;
            addr = s;
            addr_ok = 1'b1;
            break;
          end
        end
      end
      REQ_FREE: begin
        if (addr_ok && pool_active[r.slot]) begin
          wipe(r.slot);
          o.ok = 1'b1;
        end
      end
      REQ_APPEND: begin
        if (addr_ok && pool_active[r.slot]) begin
          s = r.slot;
          sq = longint'(r.dx) * r.dx + longint'(r.dy) * r.dy;
          if (sq == 0) begin
            o.dx = 16'sd16384;
            o.dy = '0;
          end else begin
            o.dx = unit_component(r.dx, sq);
            o.dy = unit_component(r.dy, sq);
          end
          if (pool_count[s] == 0) begin
            o.widx = '0;
            pool_head[s] = '0;
            pool_count[s] = 7'd1;
          end else begin
            o.widx = 6'((pool_head[s] + 1) % pool_len[s]);
            pool_head[s] = o.widx;
            if (pool_count[s] < pool_len[s]) pool_count[s]++;
          end
          o.wid = (r.wid > 0) ? r.wid : pool_width_def[s];
          o.life = pool_life_limit[s];
          pt_life[s][o.widx] = o.life;
          o.ok = 1'b1;
        end
      end
      REQ_TICK: begin
        if (r.dt != 0) begin
          o.ok = 1'b1;
          for (s = 0; s < SLOTS; s++) begin
            len = pool_len[s];
            if (!pool_active[s] || pool_count[s] == 0 || len == 0) continue;
            // Age every live point, then drop expired ones from the tail
            for (int i = 0; i < pool_count[s]; i++) begin
              k = (pool_head[s] + len - (i % len)) % len;
              pt_life[s][k] = (pt_life[s][k] > r.dt) ? pt_life[s][k] - r.dt : '0;
            end
            while (pool_count[s] > 0) begin
              k = (pool_head[s] + len - ((pool_count[s] - 1) % len)) % len;
              if (pt_life[s][k] > 0) break;
              pool_count[s]--;
            end
            if (pool_count[s] == 0) pool_head[s] = '0;
          end
        end
      end
      REQ_CLEAR: begin
        for (s = 0; s < SLOTS; s++) wipe(s);
        o.ok = 1'b1;
      end
      default: ;
    endcase
    nact = 0;
    for (s = 0; s < SLOTS; s++) nact += pool_active[s];
    o.slot = 4'(addr);
    o.live = addr_ok ? pool_count[addr] : '0;
    o.head = addr_ok ? pool_head[addr] : '0;
    o.active = 5'(nact);
    return o;
  endfunction

  // Compare each result beat with the oldest pending one
  always @(posedge clk_i) begin
    pool_resp_t e, a;
    if (rst_ni && done_o) begin
      a = '{ok_o, granted_slot_o, live_points_o, head_position_o, written_index_o,
            stored_dir_x_o, stored_dir_y_o, stored_width_o, stored_lifetime_o,
            active_slots_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        if (a != e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp %p got %p", cycles, e, a);
        end
      end
    end
  end

  // Drive one request beat and record its result when accepted
  task automatic send_req(pool_req_t r);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 23) @(negedge clk_i);
    start_i <= 1'b1;
    req_type_i <= r.kind;
    slot_number_i <= r.slot;
    pos_x_i <= r.px;
    pos_y_i <= r.py;
    dir_x_i <= r.dx;
    dir_y_i <= r.dy;
    point_width_i <= r.wid;
    point_color_i <= r.color;
    elapsed_time_i <= r.dt;
    alloc_length_i <= r.len;
    alloc_lifetime_i <= r.life;
    alloc_width_start_i <= r.wstart;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_request(r));
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TRAILS) cfg_trails = val[4:0];
    else if (idx == CFG_LIMIT) cfg_limit = val[6:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pool_req_t blank_req(logic [2:0] kind, logic [3:0] slot);
    pool_req_t r;
    r = '{kind: kind, slot: slot, px: $urandom, py: $urandom, dx: 16'($urandom),
          dy: 16'($urandom), wid: 16'($urandom), color: $urandom, dt: $urandom,
          len: 7'($urandom), life: $urandom, wstart: 16'($urandom)};
    return r;
  endfunction

  function automatic pool_req_t alloc_req(logic [6:0] len, logic [31:0] life,
                                          logic [15:0] ws);
    pool_req_t r;
    r = blank_req(REQ_ALLOC, 4'($urandom));
    r.len = len;
    r.life = life;
    r.wstart = ws;
    return r;
  endfunction

  function automatic pool_req_t append_req(logic [3:0] slot, logic signed [15:0] dx,
                                           logic signed [15:0] dy, logic signed [15:0] w);
    pool_req_t r;
    r = blank_req(REQ_APPEND, slot);
    r.dx = dx;
    r.dy = dy;
    r.wid = w;
    return r;
  endfunction

  function automatic pool_req_t tick_req(logic [31:0] dt);
    pool_req_t r;
    r = blank_req(REQ_TICK, 4'($urandom));
    r.dt = dt;
    return r;
  endfunction

  // Allocation clamps and rejection when no usable slot is free
  task automatic test_alloc_edges();
    send_req(alloc_req(7'd0, 32'd0, 16'd0));
    send_req(alloc_req(7'd127, 32'hFFFF_FFFF, 16'hFFFF));
    send_req(alloc_req(7'd3, 32'd654, 16'd25));
    drain();
    write_reg(CFG_TRAILS, 8'd3);
    send_req(alloc_req(7'd5, 32'd1000, 16'd300));
    send_req(blank_req(REQ_FREE, 4'd3));
    drain();
  endtask

  // Direction extremes, zero vector, default width, wraparound
  task automatic test_append_edges();
    send_req(append_req(4'd0, 16'sd0, 16'sd0, -16'sd5));
    send_req(append_req(4'd0, -16'sd32768, -16'sd32768, 16'sd0));
    send_req(append_req(4'd0, 16'sd32767, 16'sd1, 16'sd32767));
    send_req(append_req(4'd0, 16'sd1, -16'sd32768, -16'sd32768));
    send_req(append_req(4'd2, 16'sd3, 16'sd4, 16'sd1));
    send_req(append_req(4'd2, -16'sd3, 16'sd0, 16'sd0));
    send_req(append_req(4'd2, 16'sd7, 16'sd7, 16'sd9));
    send_req(append_req(4'd15, 16'sd7, 16'sd7, 16'sd9));
  endtask

  // Rejections, zero tick, saturating tick, unknown codes, clear-all
  task automatic test_special_cases();
    send_req(blank_req(REQ_FREE, 4'd1));
    send_req(blank_req(REQ_APPEND, 4'd1));
    send_req(tick_req(32'd0));
    send_req(tick_req(32'd700));
    send_req(tick_req(32'hFFFF_FFFF));
    send_req(blank_req(REQ_BAD, 4'd2));
    send_req(blank_req(REQ_BAD + 3'd2, 4'd9));
    send_req(blank_req(REQ_CLEAR, 4'd7));
    drain();
  endtask

  function automatic pool_req_t random_req();
    pool_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = blank_req(REQ_APPEND, 4'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                  : $urandom_range(0, usable_slots() - 1)));
    if (pick < 12) begin
      r.kind = REQ_ALLOC;
      r.len = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                           : $urandom_range(0, 12));
      r.life = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000);
    end else if (pick < 19) begin
      r.kind = REQ_FREE;
    end else if (pick < 34) begin
      r.kind = REQ_TICK;
      case ($urandom_range(0, 9))
        0:       r.dt = '0;
        1:       r.dt = $urandom;
        2, 3, 4: r.dt = $urandom_range(1, 60000);
        default: r.dt = $urandom_range(1, 3000);
      endcase
    end else if (pick < 36) begin
      r.kind = REQ_CLEAR;
    end else if (pick < 38) begin
      r.kind = REQ_BAD + 3'($urandom_range(0, 2));
    end else begin
      if ($urandom_range(0, 3) == 0) r.wid = -$signed(16'($urandom_range(0, 32768)));
      if ($urandom_range(0, 9) == 0) begin
        r.dx = '0;
        r.dy = '0;
      end else if ($urandom_range(0, 2) == 0) begin
        r.dx = $signed(16'($urandom_range(0, 64))) - 16'sd32;
        r.dy = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      end
    end
    return r;
  endfunction

  task automatic test_random(int n, logic [7:0] trails, logic [7:0] limit, bit quiet);
    write_reg(CFG_TRAILS, trails);
    write_reg(CFG_LIMIT, limit);
    no_idle = quiet;
    for (int i = 0; i < n; i++) send_req(random_req());
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    cfg_trails = TRAILS_RESET;
    cfg_limit = LIMIT_RESET;
    for (int s = 0; s < SLOTS; s++) wipe(s);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_alloc_edges();
    test_append_edges();
    test_special_cases();
    test_random(250, 8'd16, 8'd64, 1'b1);
    test_random(150, 8'd0, 8'd1, 1'b0);
    test_random(200, 8'd31, 8'd127, 1'b0);
    test_random(150, 8'd5, 8'd4, 1'b0);
    test_random(150, 8'd16, 8'd9, 1'b0);

    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** aging_ring_buffer_pool: PASSED **");
    end else begin
      $display("** aging_ring_buffer_pool: FAILED **");
    end
    $finish;
  end

endmodule
